// ===== rtl/core/lgs_pkg.sv =====
// Shared types and constants for the life grid generation step core.
// Holds grid geometry, operation codes and the sequencer state type.
// No dependencies.
package lgs_pkg;

  localparam int GRID_WIDTH  = 80;
  localparam int GRID_HEIGHT = 23;

  // Fixed widths of the row and column ports.
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;

  // Address widths into the grid memory and into one row word.
  localparam int ROW_AW = $clog2(GRID_HEIGHT);
  localparam int COL_AW = $clog2(GRID_WIDTH);

  typedef logic [GRID_WIDTH-1:0] row_word_t;
  typedef logic [ROW_AW-1:0]     row_addr_t;
  typedef logic [COL_AW-1:0]     col_addr_t;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_TOGGLE = 2'd2,
    OP_STEP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_PRIME,
    ST_SWEEP
  } state_t;

endpackage

// ===== rtl/core/lgs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lgs_row_update.sv =====
// Next-generation row from three neighboring rows, rule B3/S23, dead border.
// Depends on lgs_pkg.
module lgs_row_update (
  input  lgs_pkg::row_word_t above,
  input  lgs_pkg::row_word_t center,
  input  lgs_pkg::row_word_t below,
  output lgs_pkg::row_word_t next_row
);
  import lgs_pkg::*;

  localparam int PW = GRID_WIDTH + 2;

  logic [PW-1:0] pa;
  logic [PW-1:0] pc;
  logic [PW-1:0] pb;

  // Pad each row with a dead cell on either side.
  assign pa = {1'b0, above, 1'b0};
  assign pc = {1'b0, center, 1'b0};
  assign pb = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] n;
    next_row = '0;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
        + 4'(pc[c])               + 4'(pc[c+2])
        + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      next_row[c] = (n == 4'd3) || (center[c] && (n == 4'd2));
    end
  end

endmodule

// ===== rtl/core/life_grid_generation_step_core.sv =====
// Top level of the life grid generation step core.
// Depends on lgs_pkg, lgs_ram and lgs_row_update.
module life_grid_generation_step_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         operation,
  input  logic [lgs_pkg::ROW_FIELD_W-1:0]    row,
  input  logic [lgs_pkg::COL_FIELD_W-1:0]    column,
  input  logic                               value,
  input  logic                               cfg_write,
  input  logic                               cfg_data,
  output logic                               done,
  output logic                               cell_state
);
  // Game of Life (B3/S23) grid engine. The grid lives in a row-wide memory,
  // one word per row. A transaction is accepted at a clock edge where start
  // is high and busy is low; its single result appears on cell_state for
  // exactly one cycle with done high, and the receiver cannot stall it, so
  // sample it on that cycle. A read, write or toggle issues its memory read at
  // acceptance, keeps busy high in ST_CELL while it writes the modified row
  // back, and then strobes done. A step with run_enable set sweeps the
  // memory one row per cycle: busy stays high through a priming read in
  // ST_PRIME and then one read-modify-write per row in ST_SWEEP, and
  // cell_state returns 0. A step with run_enable clear strobes done in the
  // cycle after acceptance and leaves the grid alone. Addresses outside the
  // grid return 0 and change nothing. Reset marks every row dead through
  // per-row valid bits, so there is no clearing pass. Write run_enable
  // (cfg_write, cfg_data) only while idle.
  import lgs_pkg::*;

  state_t    state;
  state_t    state_next;
  logic      run_enable;
  logic [GRID_HEIGHT-1:0] row_valid;

  // Captured transaction.
  op_t       op_q;
  row_addr_t row_q;
  col_addr_t col_q;
  logic      value_q;
  logic      cell_ok_q;

  // Sweep state: old contents of the row above and of the current row.
  row_word_t prev_row;
  row_word_t cur_row;
  row_addr_t sweep_row;
  row_addr_t sweep_row_next;

  logic      rd_ok;
  logic      rd_ok_next;
  logic      done_next;
  logic      cell_state_next;

  logic      ram_we;
  row_addr_t ram_waddr;
  row_word_t ram_wdata;
  row_addr_t ram_raddr;
  row_word_t ram_rdata;
  row_word_t rd_word;
  row_word_t next_row;
  row_word_t cell_word;
  logic      new_bit;
  logic      accept;
  logic      addr_in_range;
  logic [ROW_AW:0] rd_ahead;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign addr_in_range = (row < GRID_HEIGHT) && (column < GRID_WIDTH);

  // Rows never written since reset read as all dead.
  assign rd_word = ram_rdata & {GRID_WIDTH{rd_ok}};

  // Two rows ahead of the row being rewritten: the next "below" row.
  assign rd_ahead = {1'b0, sweep_row} + (ROW_AW+1)'(2);

  lgs_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lgs_row_update u_row_update (
    .above    (prev_row),
    .center   (cur_row),
    .below    (rd_word),
    .next_row (next_row)
  );

  // Modify one cell of the fetched row.
  always_comb begin
    unique case (op_q)
      OP_WRITE:  new_bit = value_q;
      OP_TOGGLE: new_bit = ~rd_word[col_q];
      default:   new_bit = rd_word[col_q];
    endcase
    cell_word = rd_word;
    if (cell_ok_q) begin
      cell_word[col_q] = new_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      run_enable <= 1'b0;
      row_valid  <= '0;
      rd_ok      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      rd_ok <= rd_ok_next;
      if (cfg_write) begin
        run_enable <= cfg_data;
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    cell_state <= cell_state_next;
    sweep_row  <= sweep_row_next;
    if (accept) begin
      op_q      <= op_t'(operation);
      row_q     <= row_addr_t'(row);
      col_q     <= col_addr_t'(column);
      value_q   <= value;
      cell_ok_q <= addr_in_range;
    end
    if (state == ST_PRIME) begin
      prev_row <= '0;
      cur_row  <= rd_word;
    end else if (state == ST_SWEEP) begin
      // Shift the window down one row: keep old contents, not new.
      prev_row <= cur_row;
      cur_row  <= rd_word;
    end
  end

  always_comb begin
    state_next      = state;
    ram_we          = 1'b0;
    ram_waddr       = sweep_row;
    ram_wdata       = next_row;
    ram_raddr       = row_addr_t'(row);
    rd_ok_next      = 1'b0;
    done_next       = 1'b0;
    cell_state_next = 1'b0;
    sweep_row_next  = sweep_row;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op_t'(operation) == OP_STEP) begin
            if (run_enable) begin
              ram_raddr  = '0;
              rd_ok_next = row_valid[0];
              state_next = ST_PRIME;
            end else begin
              done_next = 1'b1;
            end
          end else begin
            ram_raddr  = row_addr_t'(row);
            rd_ok_next = addr_in_range && row_valid[ram_raddr];
            state_next = ST_CELL;
          end
        end
      end
      ST_CELL: begin
        // Write back the modified row; a plain read writes nothing.
        ram_waddr       = row_q;
        ram_wdata       = cell_word;
        ram_we          = cell_ok_q && (op_q != OP_READ);
        cell_state_next = cell_ok_q && new_bit;
        done_next       = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_PRIME: begin
        // Row 0 arrives; fetch row 1 as the first "below" row.
        ram_raddr      = row_addr_t'(1);
        rd_ok_next     = row_valid[1];
        sweep_row_next = '0;
        state_next     = ST_SWEEP;
      end
      ST_SWEEP: begin
        ram_we     = 1'b1;
        ram_waddr  = sweep_row;
        ram_wdata  = next_row;
        ram_raddr  = rd_ahead[ROW_AW-1:0];
        rd_ok_next = (rd_ahead < (ROW_AW+1)'(GRID_HEIGHT)) && row_valid[ram_raddr];
        if (sweep_row == row_addr_t'(GRID_HEIGHT - 1)) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          sweep_row_next = sweep_row + row_addr_t'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A cell transaction always answers in the cycle after its write-back.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CELL) |=> done)
    else $error("cell transaction did not strobe done");

  // Every sweep cycle rewrites one row, always inside the grid.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (ram_we && (sweep_row < GRID_HEIGHT)))
    else $error("sweep cycle without an in-range row write");

  // A finished step reports a dead cell.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && state_next == ST_IDLE) |=> (done && !cell_state))
    else $error("step result not zero");

  // The priming read always hands over to a sweep that begins at row zero.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRIME) |=> (state == ST_SWEEP && sweep_row == '0))
    else $error("sweep did not start at row zero");

endmodule
